@@ hw/rtl/bti_pkg.sv @@
// bti_pkg: shared types and constants of the bilinear table interpolator
// no dependencies; used by bti_grid_mem and bilinear_table_interp
`default_nettype none

package bti_pkg;

    // default grid size
    localparam int NX_DEFAULT = 64;
    localparam int NY_DEFAULT = 64;

    // width of index arithmetic, enough for the largest grid plus one
    localparam int IDX_W = 11;

    // one in Q16.16
    localparam int ONE_Q16 = 65536;

    // register reset values
    localparam logic [31:0] X_ORIGIN_RST = 32'h0000_0000;
    localparam logic [31:0] X_END_RST    = 32'h003F_0000;
    localparam logic [31:0] X_INV_RST    = 32'h0001_0000;
    localparam logic [31:0] Y_ORIGIN_RST = 32'h0000_0000;
    localparam logic [31:0] Y_END_RST    = 32'h003F_0000;
    localparam logic [31:0] Y_INV_RST    = 32'h0001_0000;
    localparam logic [31:0] LOW_SLOPE_RST  = 32'h0000_0000;
    localparam logic [31:0] HIGH_SLOPE_RST = 32'h0000_0000;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_X_ORIGIN   = 3'd0,
        CFG_X_END      = 3'd1,
        CFG_X_INV      = 3'd2,
        CFG_Y_ORIGIN   = 3'd3,
        CFG_Y_END      = 3'd4,
        CFG_Y_INV      = 3'd5,
        CFG_LOW_SLOPE  = 3'd6,
        CFG_HIGH_SLOPE = 3'd7
    } cfg_idx_t;

    // item operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_X_LOW  = 2'd1,
        ST_X_HIGH = 2'd2
    } status_t;

    // table write request
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [31:0]       data;
    } bti_wr_t;

endpackage

`default_nettype wire

@@ hw/rtl/bilinear_table_interp.sv @@
// bilinear_table_interp: Q16.16 bilinear interpolator over a grid table
// depends on bti_pkg and bti_grid_mem
//
// Usage:
//  The input channel (in_valid / in_stall) carries one item per transfer.
//  op = write stores entry_value at (entry_row, entry_col) and gives no
//  result; op = query gives one result (value, status) on the output
//  channel (out_valid / out_stall). Writes outside the grid are dropped.
//  Registers are set through cfg_we / cfg_index / cfg_data while idle.
//  Throughput: one item per cycle while in_stall is low, back to back.
//  Pipeline: eight register stages, stage 1 to stage 7 and the output
//  register. The stages are set by the locate multipliers, the four-bank
//  table read, the corner multipliers and the corner sum.
//  Stall: while a result waits under out_stall, the whole pipeline holds
//  and in_stall is raised; nothing is lost or repeated.
//  Reset: clears the pipeline valid bits and loads the register defaults;
//  the table is not cleared and must be written before it is read.
`default_nettype none

module bilinear_table_interp #(
    parameter int NX_POINTS = bti_pkg::NX_DEFAULT,
    parameter int NY_POINTS = bti_pkg::NY_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [5:0]  entry_row,
    input  wire logic [5:0]  entry_col,
    input  wire logic [31:0] entry_value,
    input  wire logic [31:0] query_x,
    input  wire logic [31:0] query_y,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      value,
    output logic [1:0]       status,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int XW = $clog2(NX_POINTS);
    localparam int YW = $clog2(NY_POINTS);

    // configuration registers
    logic [31:0] x_origin_reg, x_end_reg, x_inv_reg;
    logic [31:0] y_origin_reg, y_end_reg, y_inv_reg;
    logic [31:0] low_slope_reg, high_slope_reg;

    logic adv;

    // stage 1: input
    logic        s1_valid_reg, s1_op_reg;
    logic [5:0]  s1_row_reg, s1_col_reg;
    logic [31:0] s1_data_reg, s1_x_reg, s1_y_reg;

    // stage 2: offsets and checks
    logic                s2_valid_reg, s2_op_reg;
    logic [5:0]          s2_row_reg, s2_col_reg;
    logic [31:0]         s2_data_reg;
    bti_pkg::status_t    s2_status_reg;
    logic [31:0]         s2_dx_reg, s2_dy_reg, s2_ua_reg, s2_ub_reg;
    logic                s2_below_reg, s2_above_reg, s2_neg_reg;

    // stage 3: locate and slope products
    logic                s3_valid_reg, s3_op_reg;
    logic [5:0]          s3_row_reg, s3_col_reg;
    logic [31:0]         s3_data_reg;
    bti_pkg::status_t    s3_status_reg;
    logic [47:0]         s3_xh_reg, s3_xl_reg, s3_yh_reg, s3_yl_reg;
    logic [63:0]         s3_sp_reg;
    logic                s3_below_reg, s3_above_reg, s3_neg_reg;

    // stage 4: cell index and fraction
    logic                s4_valid_reg, s4_op_reg;
    logic [5:0]          s4_row_reg, s4_col_reg;
    logic [31:0]         s4_data_reg;
    bti_pkg::status_t    s4_status_reg;
    logic [XW-1:0]       s4_i_reg;
    logic [YW-1:0]       s4_j_reg;
    logic [15:0]         s4_dt_reg, s4_ds_reg;
    logic                s4_edge_reg;
    logic signed [48:0]  s4_ext_reg;

    // stage 5: table data and weights
    logic                s5_valid_reg, s5_op_reg;
    bti_pkg::status_t    s5_status_reg;
    logic [32:0]         s5_w00_reg, s5_w01_reg, s5_w10_reg, s5_w11_reg;
    logic                s5_dup_reg;
    logic signed [48:0]  s5_ext_reg;

    // stage 6: corner products
    logic                s6_valid_reg, s6_op_reg;
    bti_pkg::status_t    s6_status_reg;
    logic signed [65:0]  s6_p00_reg, s6_p01_reg, s6_p10_reg, s6_p11_reg;
    logic signed [48:0]  s6_ext_reg;

    // stage 7: corner sum
    logic                s7_valid_reg, s7_op_reg;
    bti_pkg::status_t    s7_status_reg;
    logic signed [67:0]  s7_acc_reg;
    logic signed [48:0]  s7_ext_reg;

    // output register
    logic                out_valid_reg;
    logic [31:0]         value_reg;
    bti_pkg::status_t    status_reg;

    // pipeline moves unless a result waits under stall
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg   <= bti_pkg::X_ORIGIN_RST;
            x_end_reg      <= bti_pkg::X_END_RST;
            x_inv_reg      <= bti_pkg::X_INV_RST;
            y_origin_reg   <= bti_pkg::Y_ORIGIN_RST;
            y_end_reg      <= bti_pkg::Y_END_RST;
            y_inv_reg      <= bti_pkg::Y_INV_RST;
            low_slope_reg  <= bti_pkg::LOW_SLOPE_RST;
            high_slope_reg <= bti_pkg::HIGH_SLOPE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bti_pkg::CFG_X_ORIGIN:   x_origin_reg   <= cfg_data;
                bti_pkg::CFG_X_END:      x_end_reg      <= cfg_data;
                bti_pkg::CFG_X_INV:      x_inv_reg      <= cfg_data;
                bti_pkg::CFG_Y_ORIGIN:   y_origin_reg   <= cfg_data;
                bti_pkg::CFG_Y_END:      y_end_reg      <= cfg_data;
                bti_pkg::CFG_Y_INV:      y_inv_reg      <= cfg_data;
                bti_pkg::CFG_LOW_SLOPE:  low_slope_reg  <= cfg_data;
                bti_pkg::CFG_HIGH_SLOPE: high_slope_reg <= cfg_data;
                default:                 x_origin_reg   <= x_origin_reg;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            out_valid_reg <= s7_valid_reg && s7_op_reg == bti_pkg::OP_QUERY;
        end
    end

    // stage 1 capture
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg   <= op;
            s1_row_reg  <= entry_row;
            s1_col_reg  <= entry_col;
            s1_data_reg <= entry_value;
            s1_x_reg    <= query_x;
            s1_y_reg    <= query_y;
        end
    end

    // offsets from origin and end, range checks, slope operands
    logic [32:0] dx, dxe, dy, dye, slope_a, a_neg_val;
    logic [31:0] slope_b, b_abs;
    logic        x_low, x_high, y_below, y_above;
    bti_pkg::status_t st1;

    always_comb
    begin
        dx  = {s1_x_reg[31], s1_x_reg} - {x_origin_reg[31], x_origin_reg};
        dxe = {s1_x_reg[31], s1_x_reg} - {x_end_reg[31], x_end_reg};
        dy  = {s1_y_reg[31], s1_y_reg} - {y_origin_reg[31], y_origin_reg};
        dye = {s1_y_reg[31], s1_y_reg} - {y_end_reg[31], y_end_reg};
        x_low   = $signed(dx) < -33'sd1;
        x_high  = $signed(dxe) > 33'sd1;
        y_below = dy[32];
        y_above = $signed(dye) > 33'sd0;
        if (x_low)
            st1 = bti_pkg::ST_X_LOW;
        else if (x_high)
            st1 = bti_pkg::ST_X_HIGH;
        else
            st1 = bti_pkg::ST_OK;
        slope_a   = y_below ? dy : dye;
        a_neg_val = 33'd0 - slope_a;
        slope_b   = y_below ? low_slope_reg : high_slope_reg;
        b_abs     = slope_b[31] ? (32'd0 - slope_b) : slope_b;
    end

    // stage 2
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_op_reg     <= s1_op_reg;
            s2_row_reg    <= s1_row_reg;
            s2_col_reg    <= s1_col_reg;
            s2_data_reg   <= s1_data_reg;
            s2_status_reg <= st1;
            s2_dx_reg     <= ($signed(dx) > 33'sd0) ? dx[31:0] : 32'd0;
            s2_dy_reg     <= ($signed(dy) > 33'sd0) ? dy[31:0] : 32'd0;
            s2_below_reg  <= y_below;
            s2_above_reg  <= y_above;
            s2_ua_reg     <= slope_a[32] ? a_neg_val[31:0] : slope_a[31:0];
            s2_ub_reg     <= b_abs;
            s2_neg_reg    <= slope_a[32] ^ slope_b[31];
        end
    end

    // stage 3: offset times reciprocal step, slope product
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_op_reg     <= s2_op_reg;
            s3_row_reg    <= s2_row_reg;
            s3_col_reg    <= s2_col_reg;
            s3_data_reg   <= s2_data_reg;
            s3_status_reg <= s2_status_reg;
            s3_below_reg  <= s2_below_reg;
            s3_above_reg  <= s2_above_reg;
            s3_neg_reg    <= s2_neg_reg;
            s3_xh_reg     <= 48'(s2_dx_reg[31:16]) * 48'(x_inv_reg);
            s3_xl_reg     <= 48'(s2_dx_reg[15:0]) * 48'(x_inv_reg);
            s3_yh_reg     <= 48'(s2_dy_reg[31:16]) * 48'(y_inv_reg);
            s3_yl_reg     <= 48'(s2_dy_reg[15:0]) * 48'(y_inv_reg);
            s3_sp_reg     <= 64'(s2_ua_reg) * 64'(s2_ub_reg);
        end
    end

    // cell index with clamp to the last point, slope term rounding
    logic [48:0]        tx, ty;
    logic [XW-1:0]      i_next;
    logic [YW-1:0]      j_next;
    logic [15:0]        dt_next, ds_next;
    logic [63:0]        sp_rnd;
    logic [48:0]        ext_mag;
    logic signed [48:0] ext_next;

    always_comb
    begin
        tx = 49'(s3_xh_reg) + 49'(s3_xl_reg[47:16]);
        ty = 49'(s3_yh_reg) + 49'(s3_yl_reg[47:16]);
        if (tx[48:16] > 33'(NX_POINTS - 1))
        begin
            i_next  = XW'(NX_POINTS - 1);
            dt_next = 16'd0;
        end
        else
        begin
            i_next  = tx[XW+15:16];
            dt_next = tx[15:0];
        end
        if (s3_below_reg)
        begin
            j_next  = '0;
            ds_next = 16'd0;
        end
        else if (s3_above_reg)
        begin
            j_next  = YW'(NY_POINTS - 1);
            ds_next = 16'd0;
        end
        else if (ty[48:16] > 33'(NY_POINTS - 1))
        begin
            j_next  = YW'(NY_POINTS - 1);
            ds_next = 16'd0;
        end
        else
        begin
            j_next  = ty[YW+15:16];
            ds_next = ty[15:0];
        end
        sp_rnd   = s3_sp_reg + 64'd32768;
        ext_mag  = {1'b0, sp_rnd[63:16]};
        ext_next = s3_neg_reg ? $signed(49'd0 - ext_mag) : $signed(ext_mag);
        if (!s3_below_reg && !s3_above_reg)
            ext_next = '0;
    end

    // stage 4
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_op_reg     <= s3_op_reg;
            s4_row_reg    <= s3_row_reg;
            s4_col_reg    <= s3_col_reg;
            s4_data_reg   <= s3_data_reg;
            s4_status_reg <= s3_status_reg;
            s4_i_reg      <= i_next;
            s4_j_reg      <= j_next;
            s4_dt_reg     <= dt_next;
            s4_ds_reg     <= ds_next;
            s4_edge_reg   <= s3_below_reg || s3_above_reg;
            s4_ext_reg    <= ext_next;
        end
    end

    // table access: writes and corner reads both at this stage keep order
    bti_pkg::bti_wr_t wr;
    logic [31:0]      q00, q01, q10, q11;

    always_comb
    begin
        wr.row  = bti_pkg::IDX_W'(s4_row_reg);
        wr.col  = bti_pkg::IDX_W'(s4_col_reg);
        wr.data = s4_data_reg;
        wr.en   = adv && s4_valid_reg && s4_op_reg == bti_pkg::OP_WRITE
                  && wr.row < bti_pkg::IDX_W'(NX_POINTS)
                  && wr.col < bti_pkg::IDX_W'(NY_POINTS);
    end

    bti_grid_mem #(
        .NX_POINTS (NX_POINTS),
        .NY_POINTS (NY_POINTS)
    ) u_mem (
        .clk    (clk),
        .wr     (wr),
        .rd_en  (adv),
        .rd_row (s4_i_reg),
        .rd_col (s4_j_reg),
        .q00    (q00),
        .q01    (q01),
        .q10    (q10),
        .q11    (q11)
    );

    // corner weights; terms past the table edge are dropped
    logic [16:0] wx0, wx1, wy0, wy1;
    logic        xin, yin;

    always_comb
    begin
        wx0 = 17'(bti_pkg::ONE_Q16) - {1'b0, s4_dt_reg};
        wx1 = {1'b0, s4_dt_reg};
        wy0 = 17'(bti_pkg::ONE_Q16) - {1'b0, s4_ds_reg};
        wy1 = {1'b0, s4_ds_reg};
        xin = s4_i_reg != XW'(NX_POINTS - 1);
        yin = s4_j_reg != YW'(NY_POINTS - 1);
    end

    // stage 5
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_op_reg     <= s4_op_reg;
            s5_status_reg <= s4_status_reg;
            s5_ext_reg    <= s4_ext_reg;
            s5_dup_reg    <= s4_edge_reg && !xin;
            s5_w00_reg    <= 33'(wx0) * 33'(wy0);
            s5_w01_reg    <= yin ? 33'(wx0) * 33'(wy1) : 33'd0;
            s5_w10_reg    <= (xin || s4_edge_reg) ? 33'(wx1) * 33'(wy0) : 33'd0;
            s5_w11_reg    <= (xin && yin) ? 33'(wx1) * 33'(wy1) : 33'd0;
        end
    end

    // on the edge row at the last x point both x terms use the same entry
    logic [31:0] q10_sel;
    assign q10_sel = s5_dup_reg ? q00 : q10;

    // stage 6
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_op_reg     <= s5_op_reg;
            s6_status_reg <= s5_status_reg;
            s6_ext_reg    <= s5_ext_reg;
            s6_p00_reg    <= $signed(q00) * $signed({1'b0, s5_w00_reg});
            s6_p01_reg    <= $signed(q01) * $signed({1'b0, s5_w01_reg});
            s6_p10_reg    <= $signed(q10_sel) * $signed({1'b0, s5_w10_reg});
            s6_p11_reg    <= $signed(q11) * $signed({1'b0, s5_w11_reg});
        end
    end

    // stage 7: sum with rounding half up
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_op_reg     <= s6_op_reg;
            s7_status_reg <= s6_status_reg;
            s7_ext_reg    <= s6_ext_reg;
            s7_acc_reg    <= 68'(s6_p00_reg) + 68'(s6_p01_reg) + 68'(s6_p10_reg)
                             + 68'(s6_p11_reg) + 68'sd2147483648;
        end
    end

    // scale back, add slope term, saturate; a result with an error status is zero
    logic signed [35:0] base;
    logic signed [49:0] total;
    logic [31:0]        value_next;

    always_comb
    begin
        base  = s7_acc_reg[67:32];
        total = 50'(base) + 50'(s7_ext_reg);
        if (total > 50'sd2147483647)
            value_next = 32'h7FFF_FFFF;
        else if (total < -50'sd2147483648)
            value_next = 32'h8000_0000;
        else
            value_next = total[31:0];
        if (s7_status_reg != bti_pkg::ST_OK)
            value_next = 32'd0;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg  <= value_next;
            status_reg <= s7_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    // an error result carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != bti_pkg::ST_OK |-> value == 32'd0)
        else $error("error result with nonzero value");

    // a table write never turns into a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s7_valid_reg && s7_op_reg == bti_pkg::OP_WRITE |=> !out_valid_reg)
        else $error("write item produced a result");

    // a held result freezes the pipeline
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s4_valid_reg) && $stable(s7_valid_reg))
        else $error("pipeline moved under stall");

    // shared x entry on the edge row comes with no far corner weight
    a_dup_w11: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg && s5_dup_reg |-> s5_w11_reg == 33'd0)
        else $error("far corner weight used at edge row");

endmodule

`default_nettype wire

@@ hw/rtl/bti_grid_mem.sv @@
// bti_grid_mem: grid table split in four banks by row and column parity,
// so the four corners of a cell are read together; uses bti_pkg
`default_nettype none

module bti_grid_mem #(
    parameter int NX_POINTS = bti_pkg::NX_DEFAULT,
    parameter int NY_POINTS = bti_pkg::NY_DEFAULT
) (
    input  wire logic                           clk,
    input  wire bti_pkg::bti_wr_t               wr,
    input  wire logic                           rd_en,
    input  wire logic [$clog2(NX_POINTS)-1:0]   rd_row,
    input  wire logic [$clog2(NY_POINTS)-1:0]   rd_col,
    output logic [31:0]                         q00,
    output logic [31:0]                         q01,
    output logic [31:0]                         q10,
    output logic [31:0]                         q11
);

    localparam int XW  = $clog2(NX_POINTS);
    localparam int YW  = $clog2(NY_POINTS);
    localparam int BXW = (XW > 1) ? XW - 1 : 1;
    localparam int BYW = (YW > 1) ? YW - 1 : 1;
    localparam int BANK_DEPTH = 2 ** (BXW + BYW);

    logic [bti_pkg::IDX_W-1:0] row_ext;
    logic [bti_pkg::IDX_W-1:0] row_p1;
    logic [bti_pkg::IDX_W-1:0] col_ext;
    logic [bti_pkg::IDX_W-1:0] col_p1;
    logic [31:0]               bank_q [4];
    logic                      prow_reg;
    logic                      pcol_reg;

    // row and column of the cell and of its upper neighbors
    assign row_ext = bti_pkg::IDX_W'(rd_row);
    assign row_p1  = row_ext + bti_pkg::IDX_W'(1);
    assign col_ext = bti_pkg::IDX_W'(rd_col);
    assign col_p1  = col_ext + bti_pkg::IDX_W'(1);

    // one bank per parity pair, one write and one read address each
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PR = 1'(b >> 1);
        localparam logic PC = 1'(b & 1);

        logic [31:0]          mem [BANK_DEPTH];
        logic [BXW-1:0]       ra_row;
        logic [BYW-1:0]       ra_col;

        assign ra_row = (PR == rd_row[0]) ? row_ext[BXW:1] : row_p1[BXW:1];
        assign ra_col = (PC == rd_col[0]) ? col_ext[BYW:1] : col_p1[BYW:1];

        always_ff @(posedge clk)
        begin
            if (wr.en && wr.row[0] == PR && wr.col[0] == PC)
            begin
                mem[{wr.row[BXW:1], wr.col[BYW:1]}] <= wr.data;
            end
            if (rd_en)
            begin
                bank_q[b] <= mem[{ra_row, ra_col}];
            end
        end
    end

    // parity of the cell follows the read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            prow_reg <= rd_row[0];
            pcol_reg <= rd_col[0];
        end
    end

    // route bank outputs to the corners
    always_comb
    begin
        case ({prow_reg, pcol_reg})
            2'b00:
            begin
                q00 = bank_q[0]; q01 = bank_q[1]; q10 = bank_q[2]; q11 = bank_q[3];
            end
            2'b01:
            begin
                q00 = bank_q[1]; q01 = bank_q[0]; q10 = bank_q[3]; q11 = bank_q[2];
            end
            2'b10:
            begin
                q00 = bank_q[2]; q01 = bank_q[3]; q10 = bank_q[0]; q11 = bank_q[1];
            end
            default:
            begin
                q00 = bank_q[3]; q01 = bank_q[2]; q10 = bank_q[1]; q11 = bank_q[0];
            end
        endcase
    end

endmodule

`default_nettype wire
